/* rtl/utf8d_pkg.sv */
// utf8 stream decoder shared types and constants
`timescale 1ns / 1ps

package utf8d_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CodeW  = 21;
  localparam int unsigned LenW   = 3;
  localparam int unsigned IndexW = 16;
  localparam int unsigned OwedW  = 2;

  localparam logic [3:0] Lead3Nibble = 4'hE;
  localparam logic [3:0] Lead4Nibble = 4'hF;

  localparam logic [LenW-1:0] Len1 = 3'd1;
  localparam logic [LenW-1:0] Len2 = 3'd2;
  localparam logic [LenW-1:0] Len3 = 3'd3;
  localparam logic [LenW-1:0] Len4 = 3'd4;

  typedef struct packed {
    logic             restart;
    logic [ByteW-1:0] byte_in;
  } in_item_t;

  typedef struct packed {
    logic [IndexW-1:0] char_index;
    logic [LenW-1:0]   char_bytes;
    logic [CodeW-1:0]  code_point;
  } result_t;

endpackage

/* rtl/utf8_stream_decoder.sv */
// utf8 stream decoder top level
//
// takes one utf-8 byte per transfer on the s_axis side; tuser set marks the
// first byte of a new string and drops any partial character and zeroes the
// character index. each completed character leaves as one transfer on the
// m_axis side carrying the code point, its byte length and the index.
// bytes that only extend a character produce no output transfer.
// a byte taken is held in the input register and then decoded into the result
// register, from which its result is offered on the m_axis side.
// throughput: one byte per cycle, set by the single decode step between
// the input and result registers; no bubbles while m_axis_tready stays high.
// when the receiver stalls the result register holds and the input register
// holds one more byte before s_axis_tready drops.
// reset clears the partial character, the pending count, the index and both
// valid flags; the index counter is INDEX_BITS wide and wraps.
`timescale 1ns / 1ps

module utf8_stream_decoder #(
  parameter int unsigned INDEX_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // byte_in
  input  logic        s_axis_tuser,  // restart
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // code_point, char_bytes, char_index
);

  utf8d_pkg::in_item_t in_item, reg_item;
  utf8d_pkg::result_t  dec_res, out_res;
  logic                reg_valid;
  logic                out_free;
  logic                res_valid;

  assign in_item.byte_in = s_axis_tdata;
  assign in_item.restart = s_axis_tuser;

  utf8d_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .item_i  (in_item),
    .valid_o (reg_valid),
    .ready_i (out_free),
    .item_o  (reg_item)
  );

  utf8d_decode #(
    .INDEX_BITS (INDEX_BITS)
  ) u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (reg_valid && out_free),
    .item_i      (reg_item),
    .res_valid_o (res_valid),
    .res_o       (dec_res)
  );

  utf8d_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (res_valid),
    .res_i   (dec_res),
    .free_o  (out_free),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (out_res)
  );

  assign m_axis_tdata = out_res;

endmodule

/* rtl/utf8d_in_reg.sv */
// input register stage for incoming byte transfers
`timescale 1ns / 1ps

module utf8d_in_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  utf8d_pkg::in_item_t item_i,
  output logic               valid_o,
  input  logic               ready_i,
  output utf8d_pkg::in_item_t item_o
);

  logic                valid_q;
  logic                valid_d;
  utf8d_pkg::in_item_t item_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_d = valid_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

/* rtl/utf8d_decode.sv */
// character assembly state and next-state logic
`timescale 1ns / 1ps

module utf8d_decode #(
  parameter int unsigned INDEX_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  utf8d_pkg::in_item_t item_i,
  output logic                res_valid_o,
  output utf8d_pkg::result_t  res_o
);

  logic [utf8d_pkg::CodeW-1:0] partial_q, partial_d, partial_cur;
  logic [utf8d_pkg::OwedW-1:0] owed_q, owed_d, owed_cur;
  logic [utf8d_pkg::LenW-1:0]  len_q, len_d;
  logic [INDEX_BITS-1:0]       cnt_q, cnt_d, cnt_cur;
  logic [31:0]                 cnt_ext;
  logic [utf8d_pkg::ByteW-1:0] b;
  logic                        emit;

  assign b           = item_i.byte_in;
  assign partial_cur = item_i.restart ? '0 : partial_q;
  assign owed_cur    = item_i.restart ? '0 : owed_q;
  assign cnt_cur     = item_i.restart ? '0 : cnt_q;
  assign cnt_ext     = 32'(cnt_cur);

  always_comb begin
    partial_d        = partial_cur;
    owed_d           = owed_cur;
    len_d            = len_q;
    emit             = 1'b0;
    res_o.code_point = '0;
    res_o.char_bytes = len_q;
    res_o.char_index = cnt_ext[utf8d_pkg::IndexW-1:0];
    if (owed_cur != '0) begin
      partial_d        = {partial_cur[utf8d_pkg::CodeW-7:0], b[5:0]};
      owed_d           = owed_cur - 2'd1;
      emit             = (owed_cur == 2'd1);
      res_o.code_point = partial_d;
    end else if (!b[7]) begin
      partial_d        = '0;
      len_d            = utf8d_pkg::Len1;
      emit             = 1'b1;
      res_o.code_point = utf8d_pkg::CodeW'(b);
      res_o.char_bytes = utf8d_pkg::Len1;
    end else if (b[7:4] == utf8d_pkg::Lead3Nibble) begin
      partial_d = utf8d_pkg::CodeW'(b[3:0]);
      owed_d    = 2'd2;
      len_d     = utf8d_pkg::Len3;
    end else if (b[7:4] == utf8d_pkg::Lead4Nibble) begin
      partial_d = utf8d_pkg::CodeW'(b[2:0]);
      owed_d    = 2'd3;
      len_d     = utf8d_pkg::Len4;
    end else begin
      partial_d = utf8d_pkg::CodeW'(b[4:0]);
      owed_d    = 2'd1;
      len_d     = utf8d_pkg::Len2;
    end
    cnt_d = emit ? cnt_cur + INDEX_BITS'(1) : cnt_cur;
  end

  assign res_valid_o = step_i && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= '0;
      owed_q    <= '0;
      len_q     <= '0;
      cnt_q     <= '0;
    end else if (step_i) begin
      partial_q <= partial_d;
      owed_q    <= owed_d;
      len_q     <= len_d;
      cnt_q     <= cnt_d;
    end
  end

endmodule

/* rtl/utf8d_out_reg.sv */
// result register driving the output stream
`timescale 1ns / 1ps

module utf8d_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  utf8d_pkg::result_t res_i,
  output logic               free_o,
  output logic               valid_o,
  input  logic               ready_i,
  output utf8d_pkg::result_t res_o
);

  logic               valid_q;
  logic               valid_d;
  utf8d_pkg::result_t res_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_d = load_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

/* tb/sv/tb_utf8_char_checker.sv */
// checker for the utf8 stream decoder: byte decode prediction and result compare
`timescale 1ns / 1ps

module tb_utf8_char_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // byte_in
  input  logic        s_axis_tuser,  // restart
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,  // code_point, char_bytes, char_index
  output int          outstanding_o,
  output int          mismatch_count_o
);

  logic [utf8d_pkg::CodeW-1:0]  partial_cp;
  logic [utf8d_pkg::OwedW-1:0]  owed_bytes;
  logic [utf8d_pkg::LenW-1:0]   cur_len;
  logic [utf8d_pkg::IndexW-1:0] next_index;
  utf8d_pkg::result_t           expected_chars[$];
  int                           mismatches;

  assign mismatch_count_o = mismatches;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic queue_char(input logic [utf8d_pkg::CodeW-1:0] cp,
                            input logic [utf8d_pkg::LenW-1:0] len);
    utf8d_pkg::result_t r;
    r.code_point = cp;
    r.char_bytes = len;
    r.char_index = next_index;
    expected_chars = {expected_chars, r};
    next_index = next_index + utf8d_pkg::IndexW'(1);
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic rs);
    if (rs) begin
      partial_cp = '0;
      owed_bytes = '0;
      cur_len    = '0;
      next_index = '0;
    end
    if (owed_bytes != '0) begin
      // continuation bytes are not checked, any byte gives its low six bits
      partial_cp = {partial_cp[utf8d_pkg::CodeW-7:0], b[5:0]};
      owed_bytes = owed_bytes - 2'd1;
      if (owed_bytes == '0) begin
        queue_char(partial_cp, cur_len);
      end
    end else if (!b[7]) begin
      partial_cp = '0;
      cur_len    = utf8d_pkg::Len1;
      queue_char({{(utf8d_pkg::CodeW-utf8d_pkg::ByteW){1'b0}}, b}, utf8d_pkg::Len1);
    end else if (b[7:4] == utf8d_pkg::Lead3Nibble) begin
      partial_cp = {{(utf8d_pkg::CodeW-4){1'b0}}, b[3:0]};
      owed_bytes = 2'd2;
      cur_len    = utf8d_pkg::Len3;
    end else if (b[7:4] == utf8d_pkg::Lead4Nibble) begin
      partial_cp = {{(utf8d_pkg::CodeW-3){1'b0}}, b[2:0]};
      owed_bytes = 2'd3;
      cur_len    = utf8d_pkg::Len4;
    end else begin
      partial_cp = {{(utf8d_pkg::CodeW-5){1'b0}}, b[4:0]};
      owed_bytes = 2'd1;
      cur_len    = utf8d_pkg::Len2;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    utf8d_pkg::result_t got;
    utf8d_pkg::result_t want;
    if (!rst_ni) begin
      partial_cp = '0;
      owed_bytes = '0;
      cur_len    = '0;
      next_index = '0;
      expected_chars.delete();
      outstanding_o <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = utf8d_pkg::result_t'(m_axis_tdata);
        if (expected_chars.size() == 0) begin
          report_mismatch("unexpected result transfer", m_axis_tdata[31:0], '0);
        end else begin
          want = expected_chars.pop_front();
          if (got.code_point !== want.code_point) begin
            report_mismatch("code_point", 32'(got.code_point), 32'(want.code_point));
          end
          if (got.char_bytes !== want.char_bytes) begin
            report_mismatch("char_bytes", 32'(got.char_bytes), 32'(want.char_bytes));
          end
          if (got.char_index !== want.char_index) begin
            report_mismatch("char_index", 32'(got.char_index), 32'(want.char_index));
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        decode_byte(s_axis_tdata, s_axis_tuser);
      end
      outstanding_o <= expected_chars.size();
    end
  end

endmodule

/* tb/sv/tb_utf8_stream_decoder.sv */
// testbench top for the utf8 stream decoder: clock, reset, byte stimulus and verdict
`timescale 1ns / 1ps

module tb_utf8_stream_decoder;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned PhaseBytes = 95;

  // {restart, byte}
  localparam logic [8:0] DirectedBytes [25] = '{
    9'h100, 9'h07F,                    // zero byte with restart, top ascii
    9'h080, 9'h0FF,                    // stray continuation as lead
    9'h0C3, 9'h0A9, 9'h0DF, 9'h0BF,
    9'h0E2, 9'h082, 9'h0AC,
    9'h0F0, 9'h09F, 9'h098, 9'h080,
    9'h0F8, 9'h0F0, 9'h0E0, 9'h0C0,    // lead-like bytes while owed
    9'h0E2, 9'h141,                    // restart mid-character
    9'h0FF, 9'h0BF, 9'h0BF, 9'h0BF     // largest code point
  };

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // byte_in
  logic        s_axis_tuser;   // restart
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // code_point, char_bytes, char_index
  int          outstanding;
  int          mismatch_count;
  int          tx_idle_pct;
  int          rx_stall_pct;
  logic        hold_req;
  logic        hold_done;
  int          cycle_count;

  utf8_stream_decoder u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  tb_utf8_char_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tuser     (s_axis_tuser),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .outstanding_o    (outstanding),
    .mismatch_count_o (mismatch_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    hold_done     = 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_req && !hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_done = 1'b1;
      end
      m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
      @(posedge clk_i);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic rs);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= rs;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // mostly well-formed characters, some raw bytes and broken continuations
  task automatic send_random_char(output int nbytes);
    logic [7:0] lead;
    logic       rs;
    int         len;
    rs = ($urandom_range(0, 19) == 0);
    if ($urandom_range(0, 9) == 0) begin
      send_byte(8'($urandom_range(0, 255)), rs);
      nbytes = 1;
    end else begin
      len = $urandom_range(1, 4);
      case (len)
        1: begin
          lead = 8'($urandom_range(0, 127));
        end
        2: begin
          lead = 8'hC0 + 8'($urandom_range(0, 31));
        end
        3: begin
          lead = {utf8d_pkg::Lead3Nibble, 4'h0} + 8'($urandom_range(0, 15));
        end
        default: begin
          lead = {utf8d_pkg::Lead4Nibble, 4'h0} + 8'($urandom_range(0, 15));
        end
      endcase
      send_byte(lead, rs);
      for (int k = 1; k < len; k++) begin
        if ($urandom_range(0, 15) == 0) begin
          send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        end else begin
          send_byte(8'h80 + 8'($urandom_range(0, 63)), 1'b0);
        end
      end
      nbytes = len;
    end
  endtask

  task automatic random_phase(input int tx_pct, input int rx_pct, input int count);
    int sent;
    int n;
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    sent = 0;
    while (sent < count) begin
      send_random_char(n);
      sent += n;
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  initial begin
    int n;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    tx_idle_pct   = 0;
    rx_stall_pct  = 0;
    hold_req      = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_pct  = 30;
    rx_stall_pct = 30;
    foreach (DirectedBytes[i]) begin
      send_byte(DirectedBytes[i][7:0], DirectedBytes[i][8]);
    end

    random_phase(0, 0, PhaseBytes);
    random_phase(83, 0, PhaseBytes);
    wait_drained();
    random_phase(0, 83, PhaseBytes);
    random_phase(21, 21, PhaseBytes);

    // long receiver hold-off while the sender keeps offering bytes
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_req     = 1'b1;
    for (int k = 0; k < 20; k++) begin
      send_random_char(n);
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/utf8d_pkg.sv
rtl/utf8d_in_reg.sv
rtl/utf8d_decode.sv
rtl/utf8d_out_reg.sv
rtl/utf8_stream_decoder.sv
tb/sv/tb_utf8_char_checker.sv
tb/sv/tb_utf8_stream_decoder.sv
